@@ src/rle_bitmap_decoder_top_defines.svh @@
// Assertion helpers shared by the decoder RTL.
`ifndef RLE_BITMAP_DECODER_TOP_DEFINES_SVH
`define RLE_BITMAP_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH
`define RBD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("rbd assertion failed");
`define RBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  `RBD_ASSERT(label, clk, rst_n, (ante) |-> (cons))
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  `RBD_ASSERT(label, clk, rst_n, (ante) |=> (cons))
`else
`define RBD_ASSERT(label, clk, rst_n, prop)
`define RBD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/rbd_pkg.sv @@
`default_nettype none

package rbd_pkg;

  localparam int unsigned PixelsPerByte = 8;
  localparam int unsigned PixelShift    = $clog2(PixelsPerByte);

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LengthW = 9;
  localparam int unsigned RemainW = 13;

  // A run of 256 is coded as a length byte of zero.
  localparam logic [LengthW-1:0] MaxRunLength = LengthW'(256);

  typedef struct packed {
    logic [ByteW-1:0]   value;
    logic [LengthW-1:0] length;
    logic               last;
  } run_t;

endpackage

`default_nettype wire

@@ src/rbd_core.sv @@
`default_nettype none
`include "rle_bitmap_decoder_top_defines.svh"

module rbd_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire logic [7:0]              code_byte_i,
  output logic                         emit_o,
  output rbd_pkg::run_t                run_o
);
  import rbd_pkg::*;

  typedef enum logic [2:0] {
    PH_WIDTH   = 3'd0,
    PH_HEIGHT  = 3'd1,
    PH_DATA    = 3'd2,
    PH_COMPARE = 3'd3,
    PH_COUNT   = 3'd4
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [ByteW-1:0]     width_q, width_d;
  logic [ByteW-1:0]     pend_q, pend_d;
  logic [RemainW-1:0]   rem_q, rem_d;

  logic [2*ByteW-1:0]   product;
  logic [RemainW-1:0]   size;
  logic [LengthW-1:0]   len_raw;
  logic [LengthW-1:0]   len_clip;
  logic [RemainW-1:0]   owed;
  logic                 emit;

  assign product = width_q * code_byte_i;
  assign size    = RemainW'(product >> PixelShift);

  // Literal runs are one byte; a repeat run takes its length from the count byte.
  assign len_raw  = (phase_q == PH_COUNT)
                    ? ((code_byte_i == '0) ? MaxRunLength : {1'b0, code_byte_i})
                    : LengthW'(1);
  // Clip to what the bitmap still owes.
  assign len_clip = (rem_q < RemainW'(len_raw)) ? rem_q[LengthW-1:0] : len_raw;
  assign owed     = rem_q - RemainW'(len_clip);

  always_comb begin
    phase_d = phase_q;
    width_d = width_q;
    pend_d  = pend_q;
    rem_d   = rem_q;
    emit    = 1'b0;
    unique case (phase_q)
      PH_HEIGHT: begin
        rem_d   = size;
        phase_d = (size == '0) ? PH_WIDTH : PH_DATA;
      end
      PH_DATA: begin
        pend_d  = code_byte_i;
        phase_d = PH_COMPARE;
      end
      PH_COMPARE: begin
        if (code_byte_i == pend_q) begin
          phase_d = PH_COUNT;
        end else begin
          emit  = 1'b1;
          rem_d = owed;
          // The byte that broke the literal opens the next header when the bitmap is done.
          if (owed == '0) begin
            width_d = code_byte_i;
            phase_d = PH_HEIGHT;
          end else begin
            pend_d  = code_byte_i;
            phase_d = PH_COMPARE;
          end
        end
      end
      PH_COUNT: begin
        emit    = 1'b1;
        rem_d   = owed;
        phase_d = (owed == '0) ? PH_WIDTH : PH_DATA;
      end
      default: begin
        width_d = code_byte_i;
        phase_d = PH_HEIGHT;
      end
    endcase
  end

  assign emit_o       = accept_i && emit;
  assign run_o.value  = pend_q;
  assign run_o.length = len_clip;
  assign run_o.last   = (owed == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WIDTH;
      width_q <= '0;
      pend_q  <= '0;
      rem_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      width_q <= width_d;
      pend_q  <= pend_d;
      rem_q   <= rem_d;
    end
  end

  `RBD_ASSERT_IMPL(a_body_owes, clk_i, rst_ni,
                   phase_q == PH_COMPARE || phase_q == PH_COUNT, rem_q != '0)
  `RBD_ASSERT_IMPL(a_len_in_budget, clk_i, rst_ni,
                   emit_o, RemainW'(run_o.length) <= rem_q && run_o.length != '0)
  `RBD_ASSERT_NEXT(a_last_to_header, clk_i, rst_ni, emit_o && run_o.last,
                   (phase_q == PH_WIDTH || phase_q == PH_HEIGHT) && rem_q == '0)

endmodule

`default_nettype wire

@@ src/rbd_skid.sv @@
`default_nettype none
`include "rle_bitmap_decoder_top_defines.svh"

module rbd_skid (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rbd_pkg::run_t push_data_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rbd_pkg::run_t      out_data_o
);
  import rbd_pkg::*;

  logic  out_valid_q;
  run_t  out_q;
  logic  skid_valid_q;
  run_t  skid_q;
  logic  pop;

  assign pop         = out_valid_q && out_ready_i;
  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      // Refill the output slot, oldest transaction first.
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  `RBD_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `RBD_ASSERT_IMPL(a_no_push_when_full, clk_i, rst_ni, skid_valid_q, !push_i)
  `RBD_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_valid_q && pop,
                   out_valid_q && !skid_valid_q)

endmodule

`default_nettype wire

@@ src/rle_bitmap_decoder_top.sv @@
`default_nettype none
// Run-length bitmap decoder.
// Input channel (in_valid_i/in_ready_o, code_byte_i) carries the compressed
// stream one byte per transaction: width byte, height byte, then the body.
// Output channel (out_valid_o/out_ready_i) carries one run per transaction:
// run_value_o repeated run_length_o times (1..256), last_o on the run that
// completes width*height/8 bytes. A header whose size is zero yields no runs.
// Throughput: one byte per cycle while in_ready_o is high; each byte is
// decoded by a compare, an 8x8 size multiply or a remaining-count subtract
// against the state registers. A completed run is registered into the
// output register, or into the skid register while that one is held.
// A two-entry output buffer (output register plus skid register) keeps input
// flowing while a run waits; in_ready_o drops only when both entries hold
// runs, and rises again as soon as the receiver takes one.
// Reset: asynchronous, active low; the decoder waits for a width byte and
// the output buffer is empty.
module rle_bitmap_decoder_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   code_byte_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [7:0]        run_value_o,
  output logic [8:0]        run_length_o,
  output logic              last_o
);
  import rbd_pkg::*;

  logic  accept;
  logic  emit;
  run_t  run;
  run_t  out_run;

  assign accept = in_valid_i && in_ready_o;

  rbd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .code_byte_i(code_byte_i),
    .emit_o     (emit),
    .run_o      (run)
  );

  rbd_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (emit),
    .push_data_i(run),
    .ready_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_run)
  );

  assign run_value_o  = out_run.value;
  assign run_length_o = out_run.length;
  assign last_o       = out_run.last;

endmodule

`default_nettype wire

@@ tb/rle_bitmap_decoder_top_test.sv @@
`default_nettype none

module rle_bitmap_decoder_top_test;
  import rbd_pkg::*;

  localparam int unsigned RandomBytes = 1625;
  localparam int unsigned QuietTail   = 200;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned MaxReports  = 10;

  typedef enum logic [2:0] {
    AWAIT_WIDTH   = 3'd0,
    AWAIT_HEIGHT  = 3'd1,
    AWAIT_DATA    = 3'd2,
    AWAIT_COMPARE = 3'd3,
    AWAIT_COUNT   = 3'd4
  } decode_phase_e;

  typedef struct {
    logic [ByteW-1:0] code;
    bit               typed;
    bit               has_run;
    run_t             run;
  } code_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [ByteW-1:0]   code_byte_i = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [ByteW-1:0]   run_value_o;
  logic [LengthW-1:0] run_length_o;
  logic               last_o;

  // Decoder state as seen by the predictor.
  decode_phase_e      phase = AWAIT_WIDTH;
  logic [ByteW-1:0]   header_width = '0;
  logic [ByteW-1:0]   pending_byte = '0;
  logic [RemainW-1:0] bytes_owed = '0;

  run_t queued_runs [$];
  int unsigned bytes_sent, headers_seen, runs_checked, runs_clipped, bitmaps_done;
  int unsigned failures;
  bit idle_on = 1'b1;
  bit long_hold_done = 1'b0;

  // Typed expectations cover reset, zero size, clipping and a literal that
  // ends the bitmap; the rest follows the predictor.
  code_row_t directed_rows [25] = '{
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'h08, 1'b1, 1'b0, '0},
    '{8'h03, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, {8'hFF, 9'd3, 1'b1}},
    '{8'h10, 1'b1, 1'b0, '0},
    '{8'h01, 1'b1, 1'b0, '0},
    '{8'hAA, 1'b1, 1'b0, '0},
    '{8'h55, 1'b1, 1'b1, {8'hAA, 9'd1, 1'b0}},
    '{8'h33, 1'b1, 1'b1, {8'h55, 9'd1, 1'b1}},
    '{8'h08, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h05, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0}
  };

  rle_bitmap_decoder_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_byte_i  (code_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .run_value_o  (run_value_o),
    .run_length_o (run_length_o),
    .last_o       (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("rle_bitmap_decoder_top regression: fail");
    $finish;
  end

  // Advance the decoder model by one code byte.
  function automatic void decode_byte(input logic [ByteW-1:0] b, output bit produced,
                                      output run_t run);
    int unsigned want, owed, size;
    produced = 1'b0;
    run      = '0;
    want     = 0;
    case (phase)
      AWAIT_HEIGHT: begin
        size = (int'(header_width) * int'(b)) / PixelsPerByte;
        bytes_owed = RemainW'(size);
        headers_seen++;
        phase = (size == 0) ? AWAIT_WIDTH : AWAIT_DATA;
      end
      AWAIT_DATA: begin
        pending_byte = b;
        phase = AWAIT_COMPARE;
      end
      AWAIT_COMPARE: begin
        if (b == pending_byte) begin
          phase = AWAIT_COUNT;
        end else begin
          want = 1;
          produced = 1'b1;
        end
      end
      AWAIT_COUNT: begin
        want = (b == 0) ? 256 : int'(b);
        produced = 1'b1;
      end
      default: begin
        header_width = b;
        phase = AWAIT_HEIGHT;
      end
    endcase
    if (produced) begin
      owed = bytes_owed;
      if (want > owed) begin
        want = owed;
        runs_clipped++;
      end
      owed -= want;
      bytes_owed = RemainW'(owed);
      run.value  = pending_byte;
      run.length = LengthW'(want);
      run.last   = (owed == 0);
      if (owed == 0) bitmaps_done++;
      if (phase == AWAIT_COUNT) begin
        phase = (owed == 0) ? AWAIT_WIDTH : AWAIT_DATA;
      end else if (owed == 0) begin
        // The byte that broke the literal opens the next header.
        header_width = b;
        phase = AWAIT_HEIGHT;
      end else begin
        pending_byte = b;
      end
    end
  endfunction

  // Mostly well-formed streams with small bitmaps, now and then a large one
  // or a stray byte.
  function automatic logic [ByteW-1:0] pick_code_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return ByteW'($urandom_range(0, 255));
    case (phase)
      AWAIT_WIDTH: begin
        if (r < 9) return 8'hFF;
        if (r < 14) return 8'h00;
        return ByteW'($urandom_range(1, 48));
      end
      AWAIT_HEIGHT: begin
        if (header_width >= 8'd200) return ByteW'($urandom_range(0, 255));
        return ByteW'($urandom_range(0, 40));
      end
      AWAIT_COMPARE: begin
        if (r < 55) return pending_byte;
        return ByteW'($urandom_range(0, 255));
      end
      AWAIT_COUNT: begin
        if (r < 20) return 8'h00;
        if (r < 60) return ByteW'($urandom_range(1, 8));
        return ByteW'($urandom_range(0, 255));
      end
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit idling_allowed();
    return idle_on && ((bytes_sent / 100) % 3 != 2);
  endfunction

  task automatic report_failure(input string what);
    if (failures < MaxReports) $display("[%0t] %s", $time, what);
    failures++;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input bit typed, input bit has_run,
                           input run_t typed_run);
    bit   produced;
    run_t predicted;
    if (idling_allowed() && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    code_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    decode_byte(b, produced, predicted);
    if (typed) begin
      if (has_run) queued_runs.push_back(typed_run);
    end else if (produced) begin
      queued_runs.push_back(predicted);
    end
  endtask

  // Output side: check each transaction, then pick the next ready level.
  initial begin
    int unsigned hold;
    run_t want;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        runs_checked++;
        if (queued_runs.size() == 0) begin
          report_failure($sformatf("unexpected run value=%h length=%0d last=%b",
                                   run_value_o, run_length_o, last_o));
        end else begin
          want = queued_runs.pop_front();
          if (run_value_o !== want.value || run_length_o !== want.length ||
              last_o !== want.last) begin
            report_failure($sformatf(
              "run mismatch: expected value=%h length=%0d last=%b, got value=%h length=%0d last=%b",
              want.value, want.length, want.last, run_value_o, run_length_o, last_o));
          end
        end
      end
      if (hold > 0) begin
        hold--;
      end else if (!long_hold_done && bytes_sent >= 600) begin
        // Hold off long enough for the output buffer to fill and stall input.
        long_hold_done = 1'b1;
        hold = LongHold;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 9);
      end
      out_ready_i <= (hold == 0);
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].code, directed_rows[i].typed, directed_rows[i].has_run,
                directed_rows[i].run);
    end
    for (int unsigned i = 0; i < RandomBytes; i++) begin
      if (i >= RandomBytes - QuietTail) idle_on = 1'b0;
      send_byte(pick_code_byte(), 1'b0, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (queued_runs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d code bytes over %0d headers; checked %0d runs.",
             bytes_sent, headers_seen, runs_checked);
    $display("%0d runs were clipped to the bytes owed and %0d bitmaps completed.",
             runs_clipped, bitmaps_done);
    if (failures == 0) begin
      $display("rle_bitmap_decoder_top regression: pass");
    end else begin
      $display("rle_bitmap_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
